### hdl/tldmc_pkg.sv
// ----------------------------------------------------------------------------
// Two-level cache package
// Shared types, constants and default geometry for the two-level
// direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package tldmc_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int MEM_BYTES_DEF     = 65536;
    localparam int BLOCK_BYTES_DEF   = 32;
    localparam int WORD_BYTES        = 4;
    localparam int L1_LINE_COUNT_DEF = 256;
    localparam int L2_LINE_COUNT_DEF = 512;

    // Fixed field widths.
    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 32;
    localparam int COST_W    = 19;
    localparam int LAT_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_L1_READ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_WRITE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L2_READ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L2_WRITE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_READ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_WRITE = 3'd5;

    // Reset values of the latency registers.
    localparam logic [LAT_W-1:0] L1_READ_RST   = 16'd1;
    localparam logic [LAT_W-1:0] L1_WRITE_RST  = 16'd1;
    localparam logic [LAT_W-1:0] L2_READ_RST   = 16'd10;
    localparam logic [LAT_W-1:0] L2_WRITE_RST  = 16'd10;
    localparam logic [LAT_W-1:0] MEM_READ_RST  = 16'd100;
    localparam logic [LAT_W-1:0] MEM_WRITE_RST = 16'd50;

    // Input word: one read or write access.
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] write_data;
    } in_word_t;

    // Output word: result of one access.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              l1_hit;
        logic              l2_hit;
        logic [COST_W-1:0] access_cost;
        logic [DATA_W-1:0] total_time;
    } out_word_t;

    // Latency configuration handed to the back end.
    typedef struct packed {
        logic [LAT_W-1:0] l1_rd;
        logic [LAT_W-1:0] l1_wr;
        logic [LAT_W-1:0] l2_rd;
        logic [LAT_W-1:0] l2_wr;
        logic [LAT_W-1:0] mem_rd;
        logic [LAT_W-1:0] mem_wr;
    } lat_cfg_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L1_RD,
        S_L1_TAG,
        S_L2_RD,
        S_L2_TAG,
        S_L2_EVICT,
        S_L2_FILL,
        S_L2_XFER,
        S_L1_WORD,
        S_DONE
    } cache_state_t;

endpackage

### hdl/tldmc_front.sv
// ----------------------------------------------------------------------------
// Cache front end
// Accepts access words, wraps the address into memory and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module tldmc_front
    import tldmc_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  in_word_t                                in_word,
    input  logic                                    clearing,
    output logic                                    q_valid,
    input  logic                                    q_pop,
    output logic                                    q_kind,
    output logic [DATA_W-1:0]                       q_wdata,
    output logic [$clog2(MEM_BYTES/WORD_BYTES)-1:0] q_addr
);

    localparam int WA_W  = $clog2(MEM_BYTES / WORD_BYTES);
    localparam int EXT_W = (WA_W > ADDR_W) ? WA_W : ADDR_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              kind_q  [QUEUE_DEPTH];
    logic [DATA_W-1:0] wdata_q [QUEUE_DEPTH];
    logic [WA_W-1:0]   addr_q  [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [EXT_W-1:0] addr_ext;
    logic             push;

    // The address wraps modulo the memory size in words.
    assign addr_ext = EXT_W'(in_word.word_address);

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH)) && !clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_kind   = kind_q[rd_ptr_reg];
    assign q_wdata  = wdata_q[rd_ptr_reg];
    assign q_addr   = addr_q[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_q[wr_ptr_reg]  <= in_word.kind;
            wdata_q[wr_ptr_reg] <= in_word.write_data;
            addr_q[wr_ptr_reg]  <= addr_ext[WA_W-1:0];
        end
    end

endmodule

### hdl/tldmc_back.sv
// ----------------------------------------------------------------------------
// Cache back end
// Sequencer that looks up L1 and L2, moves whole blocks word by word between
// the levels and main memory, and registers the result word.
// ----------------------------------------------------------------------------
module tldmc_back
    import tldmc_pkg::*;
#(
    parameter int MEM_BYTES     = MEM_BYTES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    parameter int L1_LINE_COUNT = L1_LINE_COUNT_DEF,
    parameter int L2_LINE_COUNT = L2_LINE_COUNT_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lat_cfg_t                                lat,
    output logic                                    clearing,
    input  logic                                    q_valid,
    output logic                                    q_pop,
    input  logic                                    q_kind,
    input  logic [DATA_W-1:0]                       q_wdata,
    input  logic [$clog2(MEM_BYTES/WORD_BYTES)-1:0] q_addr,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output out_word_t                               out_word
);

    localparam int MEM_WORDS = MEM_BYTES / WORD_BYTES;
    localparam int WPB       = BLOCK_BYTES / WORD_BYTES;
    localparam int OFF_W     = $clog2(WPB);
    localparam int WA_W      = $clog2(MEM_WORDS);
    localparam int BLK_W     = WA_W - OFF_W;
    localparam int L1I_W     = $clog2(L1_LINE_COUNT);
    localparam int L2I_W     = $clog2(L2_LINE_COUNT);
    localparam int L1T_W     = BLK_W - L1I_W;
    localparam int L2T_W     = BLK_W - L2I_W;
    localparam int L1M_W     = L1T_W + 2;
    localparam int L2M_W     = L2T_W + 2;
    localparam int CNT_W     = OFF_W + 1;
    localparam int CLR_A     = (MEM_WORDS > L2_LINE_COUNT) ? MEM_WORDS : L2_LINE_COUNT;
    localparam int CLR_N     = (CLR_A > L1_LINE_COUNT) ? CLR_A : L1_LINE_COUNT;
    localparam int CLR_W     = $clog2(CLR_N) + 1;

    // Storage: tag stores hold {valid, dirty, tag}.
    logic [L1M_W-1:0]  l1_meta  [L1_LINE_COUNT];
    logic [L2M_W-1:0]  l2_meta  [L2_LINE_COUNT];
    logic [DATA_W-1:0] l1_words [L1_LINE_COUNT * WPB];
    logic [DATA_W-1:0] l2_words [L2_LINE_COUNT * WPB];
    logic [DATA_W-1:0] main_mem [MEM_WORDS];

    cache_state_t state_reg, state_next;

    logic              kind_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  blk2_reg;
    logic              op_wr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [L2M_W-1:0]  l2_old_reg;
    logic              hit1_reg;
    logic              hit2_reg;
    logic [COST_W-1:0] cost_reg;
    logic [DATA_W-1:0] total_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    // Memory ports.
    logic [L1M_W-1:0]       l1m_rd;
    logic                   l1m_we;
    logic [L1I_W-1:0]       l1m_wa;
    logic [L1M_W-1:0]       l1m_wd;
    logic [L2M_W-1:0]       l2m_rd;
    logic                   l2m_we;
    logic [L2I_W-1:0]       l2m_wa;
    logic [L2M_W-1:0]       l2m_wd;
    logic [DATA_W-1:0]      l1w_rd;
    logic [L1I_W+OFF_W-1:0] l1w_ra;
    logic                   l1w_we;
    logic [L1I_W+OFF_W-1:0] l1w_wa;
    logic [DATA_W-1:0]      l1w_wd;
    logic [DATA_W-1:0]      l2w_rd;
    logic [L2I_W+OFF_W-1:0] l2w_ra;
    logic                   l2w_we;
    logic [L2I_W+OFF_W-1:0] l2w_wa;
    logic [DATA_W-1:0]      l2w_wd;
    logic [DATA_W-1:0]      mem_rd;
    logic [WA_W-1:0]        mem_ra;
    logic                   mem_we;
    logic [WA_W-1:0]        mem_wa;
    logic [DATA_W-1:0]      mem_wd;

    // Decoded fields and lookup results.
    logic [L1I_W-1:0] l1_idx;
    logic [L1T_W-1:0] l1_tag;
    logic [L2I_W-1:0] l2_idx;
    logic [L2T_W-1:0] l2_tag;
    logic [OFF_W-1:0] cnt_lo;
    logic [OFF_W-1:0] wcnt;
    logic             cnt_last;
    logic             hit1;
    logic             hit2;
    logic             l1_victim;
    logic             l2_victim;
    logic [COST_W-1:0] l2_cost;
    logic              out_load;

    assign l1_idx   = blk_reg[L1I_W-1:0];
    assign l1_tag   = blk_reg[BLK_W-1:L1I_W];
    assign l2_idx   = blk2_reg[L2I_W-1:0];
    assign l2_tag   = blk2_reg[BLK_W-1:L2I_W];
    assign cnt_lo   = cnt_reg[OFF_W-1:0];
    assign wcnt     = OFF_W'(cnt_reg - CNT_W'(1));
    assign cnt_last = (cnt_reg == CNT_W'(WPB));

    assign hit1      = l1m_rd[L1M_W-1] && (l1m_rd[L1T_W-1:0] == l1_tag);
    assign l1_victim = l1m_rd[L1M_W-1] && l1m_rd[L1M_W-2];
    assign hit2      = l2m_rd[L2M_W-1] && (l2m_rd[L2T_W-1:0] == l2_tag);
    assign l2_victim = l2m_rd[L2M_W-1] && l2m_rd[L2M_W-2];

    // Cost of one L2 block access: optional eviction, fill, then the L2 access.
    assign l2_cost = COST_W'(op_wr_reg ? lat.l2_wr : lat.l2_rd)
                   + (hit2 ? '0 : COST_W'(lat.mem_rd))
                   + ((!hit2 && l2_victim) ? COST_W'(lat.mem_wr) : '0);

    assign clearing  = (state_reg == S_CLEAR);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_L1_RD;
                end
            end
            S_L1_RD:
            begin
                state_next = S_L1_TAG;
            end
            S_L1_TAG:
            begin
                state_next = hit1 ? S_L1_WORD : S_L2_RD;
            end
            S_L2_RD:
            begin
                state_next = S_L2_TAG;
            end
            S_L2_TAG:
            begin
                if (hit2)
                begin
                    state_next = S_L2_XFER;
                end
                else if (l2_victim)
                begin
                    state_next = S_L2_EVICT;
                end
                else
                begin
                    // A whole-block write needs no fill from memory.
                    state_next = op_wr_reg ? S_L2_XFER : S_L2_FILL;
                end
            end
            S_L2_EVICT:
            begin
                if (cnt_last)
                begin
                    state_next = op_wr_reg ? S_L2_XFER : S_L2_FILL;
                end
            end
            S_L2_FILL:
            begin
                if (cnt_last)
                begin
                    state_next = S_L2_XFER;
                end
            end
            S_L2_XFER:
            begin
                if (cnt_last)
                begin
                    state_next = op_wr_reg ? S_L2_RD : S_L1_WORD;
                end
            end
            S_L1_WORD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control for each state.
    always_comb
    begin
        l1m_we = 1'b0;
        l1m_wa = l1_idx;
        l1m_wd = {1'b1, kind_reg || (hit1 && l1m_rd[L1M_W-2]), l1_tag};
        l2m_we = 1'b0;
        l2m_wa = l2_idx;
        l2m_wd = {1'b1, op_wr_reg || (hit2 && l2m_rd[L2M_W-2]), l2_tag};
        l1w_ra = {l1_idx, off_reg};
        l1w_we = 1'b0;
        l1w_wa = {l1_idx, wcnt};
        l1w_wd = l2w_rd;
        l2w_ra = {l2_idx, cnt_lo};
        l2w_we = 1'b0;
        l2w_wa = {l2_idx, wcnt};
        l2w_wd = mem_rd;
        mem_ra = {blk2_reg, cnt_lo};
        mem_we = 1'b0;
        mem_wa = {l2_old_reg[L2T_W-1:0], l2_idx, wcnt};
        mem_wd = l2w_rd;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = (clr_reg < CLR_W'(MEM_WORDS));
                mem_wa = clr_reg[WA_W-1:0];
                mem_wd = '0;
                l1m_we = (clr_reg < CLR_W'(L1_LINE_COUNT));
                l1m_wa = clr_reg[L1I_W-1:0];
                l1m_wd = '0;
                l2m_we = (clr_reg < CLR_W'(L2_LINE_COUNT));
                l2m_wa = clr_reg[L2I_W-1:0];
                l2m_wd = '0;
            end
            S_L1_TAG:
            begin
                l1m_we = 1'b1;
            end
            S_L2_TAG:
            begin
                l2m_we = 1'b1;
            end
            S_L2_EVICT:
            begin
                mem_we = (cnt_reg != '0);
            end
            S_L2_FILL:
            begin
                l2w_we = (cnt_reg != '0);
            end
            S_L2_XFER:
            begin
                if (op_wr_reg)
                begin
                    l1w_ra = {l1_idx, cnt_lo};
                    l2w_we = (cnt_reg != '0);
                    l2w_wd = l1w_rd;
                end
                else
                begin
                    l1w_we = (cnt_reg != '0);
                end
            end
            S_L1_WORD:
            begin
                l1w_we = kind_reg;
                l1w_wa = {l1_idx, off_reg};
                l1w_wd = wdata_reg;
            end
            default:
            begin
                l1m_we = 1'b0;
            end
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (l1m_we)
        begin
            l1_meta[l1m_wa] <= l1m_wd;
        end
        l1m_rd <= l1_meta[l1_idx];
    end

    always_ff @(posedge clk)
    begin
        if (l2m_we)
        begin
            l2_meta[l2m_wa] <= l2m_wd;
        end
        l2m_rd <= l2_meta[l2_idx];
    end

    always_ff @(posedge clk)
    begin
        if (l1w_we)
        begin
            l1_words[l1w_wa] <= l1w_wd;
        end
        l1w_rd <= l1_words[l1w_ra];
    end

    always_ff @(posedge clk)
    begin
        if (l2w_we)
        begin
            l2_words[l2w_wa] <= l2w_wd;
        end
        l2w_rd <= l2_words[l2w_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_wa] <= mem_wd;
        end
        mem_rd <= main_mem[mem_ra];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next == state_reg) ? cnt_reg + CNT_W'(1) : '0;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_reg + DATA_W'(cost_reg);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload, lookup bookkeeping and the result word.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg  <= q_kind;
                wdata_reg <= q_wdata;
                off_reg   <= q_addr[OFF_W-1:0];
                blk_reg   <= q_addr[WA_W-1:OFF_W];
                cost_reg  <= '0;
                hit2_reg  <= 1'b0;
            end
            S_L1_TAG:
            begin
                hit1_reg   <= hit1;
                cost_reg   <= cost_reg + COST_W'(kind_reg ? lat.l1_wr : lat.l1_rd);
                // A dirty victim goes back to L2 before the new block comes in.
                if (l1_victim)
                begin
                    blk2_reg  <= {l1m_rd[L1T_W-1:0], l1_idx};
                    op_wr_reg <= 1'b1;
                end
                else
                begin
                    blk2_reg  <= blk_reg;
                    op_wr_reg <= 1'b0;
                end
            end
            S_L2_TAG:
            begin
                l2_old_reg <= l2m_rd;
                cost_reg   <= cost_reg + l2_cost;
                if (!op_wr_reg)
                begin
                    hit2_reg <= hit2;
                end
            end
            S_L2_XFER:
            begin
                if (cnt_last && op_wr_reg)
                begin
                    blk2_reg  <= blk_reg;
                    op_wr_reg <= 1'b0;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_word_reg.read_data   <= kind_reg ? '0 : l1w_rd;
                    out_word_reg.l1_hit      <= hit1_reg;
                    out_word_reg.l2_hit      <= hit2_reg;
                    out_word_reg.access_cost <= cost_reg;
                    out_word_reg.total_time  <= total_reg + DATA_W'(cost_reg);
                end
            end
            default:
            begin
                op_wr_reg <= op_wr_reg;
            end
        endcase
    end

endmodule

### hdl/two_level_direct_mapped_cache_top.sv
// ----------------------------------------------------------------------------
// Two-level direct-mapped cache
// Word read/write accesses through a write-back, write-allocate L1 and L2
// in front of a word-addressed main memory, with a latency cost per access.
// ----------------------------------------------------------------------------
// After reset the block clears main memory and the tag stores, one word a
// cycle for the larger of the memory size in words and the line counts,
// and accepts no word meanwhile; latency registers can be written
// throughout. One access is worked at a time by a sequencer behind a
// two-word input queue. A block moved between levels is copied one word
// per cycle, read from one memory and written to the other. The worst
// case is a miss that writes back a dirty L1 victim, with an L2 eviction
// on both block transfers.
// ----------------------------------------------------------------------------
module two_level_direct_mapped_cache_top
    import tldmc_pkg::*;
#(
    parameter int MEM_BYTES     = MEM_BYTES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    parameter int L1_LINE_COUNT = L1_LINE_COUNT_DEF,
    parameter int L2_LINE_COUNT = L2_LINE_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LAT_W-1:0]     cfg_data
);

    localparam int WA_W = $clog2(MEM_BYTES / WORD_BYTES);

    lat_cfg_t lat_reg;

    logic              clearing;
    logic              q_valid;
    logic              q_pop;
    logic              q_kind;
    logic [DATA_W-1:0] q_wdata;
    logic [WA_W-1:0]   q_addr;

    // Latency registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg.l1_rd  <= L1_READ_RST;
            lat_reg.l1_wr  <= L1_WRITE_RST;
            lat_reg.l2_rd  <= L2_READ_RST;
            lat_reg.l2_wr  <= L2_WRITE_RST;
            lat_reg.mem_rd <= MEM_READ_RST;
            lat_reg.mem_wr <= MEM_WRITE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_L1_READ:   lat_reg.l1_rd  <= cfg_data;
                REG_L1_WRITE:  lat_reg.l1_wr  <= cfg_data;
                REG_L2_READ:   lat_reg.l2_rd  <= cfg_data;
                REG_L2_WRITE:  lat_reg.l2_wr  <= cfg_data;
                REG_MEM_READ:  lat_reg.mem_rd <= cfg_data;
                REG_MEM_WRITE: lat_reg.mem_wr <= cfg_data;
                default:       lat_reg        <= lat_reg;
            endcase
        end
    end

    // Front end: input queue.
    tldmc_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_kind   (q_kind),
        .q_wdata  (q_wdata),
        .q_addr   (q_addr)
    );

    // Back end: lookup and block transfer sequencer.
    tldmc_back #(
        .MEM_BYTES     (MEM_BYTES),
        .BLOCK_BYTES   (BLOCK_BYTES),
        .L1_LINE_COUNT (L1_LINE_COUNT),
        .L2_LINE_COUNT (L2_LINE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lat       (lat_reg),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_kind    (q_kind),
        .q_wdata   (q_wdata),
        .q_addr    (q_addr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

### verif/two_level_cache_checker.sv
// ----------------------------------------------------------------------------
// Two-level cache result checker
// Watches both word channels and the latency register port, keeps its own
// model of the L1, L2 and main memory contents, and compares every result
// word with the prediction for the oldest access still outstanding.
// ----------------------------------------------------------------------------
module two_level_cache_checker
    import tldmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_word_t             in_word,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_word_t            out_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LAT_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_count,
    output int                   l1_hit_count,
    output int                   l2_hit_count
);

    localparam int WPB       = BLOCK_BYTES_DEF / WORD_BYTES;
    localparam int MEM_WORDS = MEM_BYTES_DEF / WORD_BYTES;
    localparam int MEM_BLKS  = MEM_WORDS / WPB;
    localparam int L1_SETS   = L1_LINE_COUNT_DEF;
    localparam int L2_SETS   = L2_LINE_COUNT_DEF;

    // Model state.
    logic [LAT_W-1:0]  lat [6];
    bit                l1_v [L1_SETS];
    bit                l1_d [L1_SETS];
    int unsigned       l1_t [L1_SETS];
    logic [DATA_W-1:0] l1_w [L1_SETS*WPB];
    bit                l2_v [L2_SETS];
    bit                l2_d [L2_SETS];
    int unsigned       l2_t [L2_SETS];
    logic [DATA_W-1:0] l2_w [L2_SETS*WPB];
    logic [DATA_W-1:0] mem_w [MEM_WORDS];
    logic [DATA_W-1:0] run_time;
    out_word_t         expected_results [$];

    // Whole-block access to L2; the block travels through buf_w.
    function automatic int unsigned l2_block_access(int unsigned blk,
        ref logic [DATA_W-1:0] buf_w [WPB], input bit wr, output bit hit);
        int unsigned idx;
        int unsigned tg;
        int unsigned vblk;
        int unsigned cost;
        idx  = blk % L2_SETS;
        tg   = blk / L2_SETS;
        cost = 0;
        hit  = l2_v[idx] && l2_t[idx] == tg;
        if (!hit)
        begin
            if (l2_v[idx] && l2_d[idx])
            begin
                vblk = (l2_t[idx] * L2_SETS + idx) % MEM_BLKS;
                for (int i = 0; i < WPB; i++)
                    mem_w[vblk*WPB+i] = l2_w[idx*WPB+i];
                cost += lat[REG_MEM_WRITE];
            end
            for (int i = 0; i < WPB; i++)
                l2_w[idx*WPB+i] = mem_w[blk*WPB+i];
            cost += lat[REG_MEM_READ];
            l2_v[idx] = 1;
            l2_d[idx] = 0;
            l2_t[idx] = tg;
        end
        if (wr)
        begin
            for (int i = 0; i < WPB; i++)
                l2_w[idx*WPB+i] = buf_w[i];
            l2_d[idx] = 1;
            cost += lat[REG_L2_WRITE];
        end
        else
        begin
            for (int i = 0; i < WPB; i++)
                buf_w[i] = l2_w[idx*WPB+i];
            cost += lat[REG_L2_READ];
        end
        return cost;
    endfunction

    // Predicts the result word of one access and updates the model.
    function automatic out_word_t predict_access(in_word_t w);
        out_word_t r;
        int unsigned wa;
        int unsigned off;
        int unsigned blk;
        int unsigned idx;
        int unsigned tg;
        int unsigned cost;
        bit hit1;
        bit hit2;
        bit unused_hit;
        logic [DATA_W-1:0] line [WPB];
        wa   = w.word_address % MEM_WORDS;
        off  = wa % WPB;
        blk  = wa / WPB;
        idx  = blk % L1_SETS;
        tg   = blk / L1_SETS;
        cost = 0;
        hit2 = 0;
        r    = '0;
        for (int i = 0; i < WPB; i++)
            line[i] = l1_w[idx*WPB+i];
        hit1 = l1_v[idx] && l1_t[idx] == tg;
        if (!hit1)
        begin
            if (l1_v[idx] && l1_d[idx])
                cost += l2_block_access((l1_t[idx] * L1_SETS + idx) % MEM_BLKS,
                                        line, 1'b1, unused_hit);
            cost += l2_block_access(blk, line, 1'b0, hit2);
            l1_v[idx] = 1;
            l1_d[idx] = 0;
            l1_t[idx] = tg;
        end
        if (w.kind)
        begin
            line[off] = w.write_data;
            l1_d[idx] = 1;
            cost += lat[REG_L1_WRITE];
        end
        else
        begin
            r.read_data = line[off];
            cost += lat[REG_L1_READ];
        end
        for (int i = 0; i < WPB; i++)
            l1_w[idx*WPB+i] = line[i];
        run_time      = run_time + cost;
        r.l1_hit      = hit1;
        r.l2_hit      = hit2;
        r.access_cost = cost[COST_W-1:0];
        r.total_time  = run_time;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Reset state, then follow register writes, accesses and results.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            lat[REG_L1_READ]   = L1_READ_RST;
            lat[REG_L1_WRITE]  = L1_WRITE_RST;
            lat[REG_L2_READ]   = L2_READ_RST;
            lat[REG_L2_WRITE]  = L2_WRITE_RST;
            lat[REG_MEM_READ]  = MEM_READ_RST;
            lat[REG_MEM_WRITE] = MEM_WRITE_RST;
            for (int i = 0; i < L1_SETS; i++)
            begin
                l1_v[i] = 0; l1_d[i] = 0; l1_t[i] = 0;
            end
            for (int i = 0; i < L2_SETS; i++)
            begin
                l2_v[i] = 0; l2_d[i] = 0; l2_t[i] = 0;
            end
            for (int i = 0; i < L1_SETS*WPB; i++)
                l1_w[i] = '0;
            for (int i = 0; i < L2_SETS*WPB; i++)
                l2_w[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                mem_w[i] = '0;
            run_time = '0;
            expected_results.delete();
            fail_count   = 0;
            l1_hit_count = 0;
            l2_hit_count = 0;
        end
        else
        begin
            if (cfg_we && cfg_index <= REG_MEM_WRITE)
                lat[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no access outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_word.l1_hit) l1_hit_count++;
                    if (out_word.l2_hit) l2_hit_count++;
                    if (out_word.read_data !== e.read_data)
                    begin
                        $error("read_data expected %h actual %h",
                               e.read_data, out_word.read_data);
                        fail_count++;
                    end
                    if (out_word.l1_hit !== e.l1_hit)
                    begin
                        $error("l1_hit expected %b actual %b", e.l1_hit, out_word.l1_hit);
                        fail_count++;
                    end
                    if (out_word.l2_hit !== e.l2_hit)
                    begin
                        $error("l2_hit expected %b actual %b", e.l2_hit, out_word.l2_hit);
                        fail_count++;
                    end
                    if (out_word.access_cost !== e.access_cost)
                    begin
                        $error("access_cost expected %0d actual %0d",
                               e.access_cost, out_word.access_cost);
                        fail_count++;
                    end
                    if (out_word.total_time !== e.total_time)
                    begin
                        $error("total_time expected %0d actual %0d",
                               e.total_time, out_word.total_time);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_access(in_word));
        end
    end

endmodule

### verif/two_level_direct_mapped_cache_top_test.sv
// ----------------------------------------------------------------------------
// Two-level cache testbench
// Drives directed and random word accesses with random gaps on both
// channels, changes the latency registers between phases and leaves the
// checking to the result checker.
// ----------------------------------------------------------------------------
module two_level_direct_mapped_cache_top_test;
    import tldmc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_word;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LAT_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   l1_hit_count;
    int                   l2_hit_count;
    int                   words_sent;
    bit                   hold_off;

    two_level_direct_mapped_cache_top dut (.*);

    two_level_cache_checker checker_i (.*);

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Run limit: clearing pass plus the slowest accesses, many times over.
    initial
    begin
        #20000000;
        $display("two_level_direct_mapped_cache_top_test: FAIL");
        $finish;
    end

    // Gap length: mostly short, now and then long.
    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        else if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        bit hold_done;
        out_ready = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                hold_done = 1;
            end
            g = (words_sent < 200) ? 0 : gap_cycles();
            if (g == 0)
                out_ready <= 1;
            else
            begin
                out_ready <= 0;
                repeat (g - 1) @(posedge clk);
            end
        end
    end

    // Sends one access word and waits until it is taken; valid stays high
    // into the next word when no gap follows.
    task automatic send_access(bit wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] d,
                               bit with_gap);
        int g;
        g = with_gap ? gap_cycles() : 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        in_word  <= '{kind: wr, word_address: addr, write_data: d};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Writes one latency register; the caller drops the enable afterwards.
    task automatic write_latency(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] v);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // Stops offering words and waits until every access has its result.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_all_latencies(logic [LAT_W-1:0] v);
        for (int i = REG_L1_READ; i <= REG_MEM_WRITE; i++)
            write_latency(i[CFG_IDX_W-1:0], v);
        cfg_we <= 0;
    endtask

    // Random address near a few hot blocks, or anywhere.
    function automatic logic [ADDR_W-1:0] random_address();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35)
            return ADDR_W'($urandom_range(0, 63));
        else if (p < 60)
            // One of four L1 indexes, other tags: conflict misses.
            return ADDR_W'({$urandom_range(0, 7) * 256 + $urandom_range(0, 3), 3'(0)}
                           + $urandom_range(0, 7));
        else if (p < 75)
            // Same L2 index, other tags: L2 evictions.
            return ADDR_W'({$urandom_range(0, 3) * 512 + 5, 3'(0)} + $urandom_range(0, 7));
        return ADDR_W'($urandom());
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_access(1'($urandom_range(0, 1)), random_address(), $urandom(), 1'b1);
    endtask

    // Stimulus.
    initial
    begin
        rst_n     = 0;
        in_valid  = 0;
        in_word   = '0;
        cfg_we    = 0;
        cfg_index = '0;
        cfg_data  = '0;
        words_sent = 0;
        hold_off  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: cold read, write, read back, extremes of address and data.
        send_access(1'b0, 14'd0, 32'hFFFF_FFFF, 1'b0);
        send_access(1'b1, 14'd0, 32'hFFFF_FFFF, 1'b0);
        send_access(1'b0, 14'd0, '0, 1'b0);
        send_access(1'b1, 14'd7, 32'h0000_0000, 1'b0);
        send_access(1'b1, 14'h3FFF, 32'hA5A5_5A5A, 1'b0);
        send_access(1'b0, 14'h3FFF, '0, 1'b0);
        // Dirty L1 victim at index 0 written back to L2.
        send_access(1'b0, 14'd2048, '0, 1'b0);
        send_access(1'b0, 14'd0, '0, 1'b0);
        // Dirty L2 victim: blocks 0, 512, 1024 and 1536 share an L2 line.
        send_access(1'b1, 14'd4096, 32'h1234_5678, 1'b0);
        send_access(1'b0, 14'd8192, '0, 1'b0);
        send_access(1'b0, 14'd12288, '0, 1'b0);
        send_access(1'b0, 14'd4096, '0, 1'b0);
        send_access(1'b0, 14'd0, '0, 1'b0);
        send_access(1'b0, 14'h2AAA, '0, 1'b0);
        send_access(1'b1, 14'h1555, 32'h5555_AAAA, 1'b0);
        drain();

        // Extreme latencies.
        set_all_latencies(16'hFFFF);
        send_access(1'b1, 14'd16, 32'hDEAD_BEEF, 1'b0);
        send_access(1'b0, 14'd2064, '0, 1'b0);
        send_access(1'b0, 14'd6160, '0, 1'b0);
        send_access(1'b0, 14'd16, '0, 1'b0);
        drain();
        set_all_latencies(16'd0);
        send_access(1'b0, 14'd16, '0, 1'b0);
        send_access(1'b1, 14'd4112, 32'h0F0F_0F0F, 1'b0);
        drain();

        // Back-pressure: results held back while accesses keep coming.
        hold_off = 1;
        for (int i = 0; i < 20; i++)
            send_access(1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 31)),
                        $urandom(), 1'b0);
        drain();

        // Random phases under several latency settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int r = REG_L1_READ; r <= REG_MEM_WRITE; r++)
                write_latency(r[CFG_IDX_W-1:0], (ph == 5) ? 16'hFFFF : LAT_W'($urandom()));
            cfg_we <= 0;
            random_phase(240);
            drain();
        end

        $display("Covered %0d accesses: %0d L1 hits, %0d L2 hits.",
                 words_sent, l1_hit_count, l2_hit_count);
        if (fail_count == 0)
            $display("two_level_direct_mapped_cache_top_test: PASS");
        else
            $display("two_level_direct_mapped_cache_top_test: FAIL");
        $finish;
    end

endmodule

### two_level_direct_mapped_cache_top.f
hdl/tldmc_pkg.sv
hdl/tldmc_front.sv
hdl/tldmc_back.sv
hdl/two_level_direct_mapped_cache_top.sv
verif/two_level_cache_checker.sv
verif/two_level_direct_mapped_cache_top_test.sv
